@@ hdl/tpr_pkg.sv @@
// ----------------------------------------------------------------------------
// Telemetry poll responder package
// Shared types, codes and frame constants for the poll responder.
// ----------------------------------------------------------------------------
package tpr_pkg;

   localparam int FRAME_BYTES = 8;
   localparam int BYTE_IDX_W  = $clog2(FRAME_BYTES);
   localparam logic [BYTE_IDX_W-1:0] LAST_BYTE_IDX = BYTE_IDX_W'(FRAME_BYTES - 1);

   localparam logic [7:0] START_BYTE  = 8'h7E;
   localparam logic [7:0] HEADER_BYTE = 8'h10;
   localparam logic [7:0] TYPE_BYTE   = 8'h0B;

   // Request operation codes
   localparam logic OP_RX_BYTE  = 1'b0;
   localparam logic OP_RESP_DUE = 1'b1;

   // Result kinds
   localparam logic RESULT_POLL_MATCH = 1'b0;
   localparam logic RESULT_FRAME_BYTE = 1'b1;

   // Frame kinds, rotated one per frame
   localparam logic [1:0] KIND_BATT1  = 2'd0;
   localparam logic [1:0] KIND_BATT2  = 2'd1;
   localparam logic [1:0] KIND_SWITCH = 2'd2;

   // CSR map
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_DEVICE_ID = 1'b0;

   typedef struct packed {
      logic        op;
      logic [7:0]  rx_byte;
      logic [15:0] batt1_mv;
      logic [15:0] batt2_mv;
      logic [3:0]  switch_state;
   } req_type;

   typedef struct packed {
      logic       result_kind;
      logic [7:0] tx_byte;
      logic       tx_last;
   } rsp_type;

   typedef logic [FRAME_BYTES-1:0][7:0] frame_type;

   // Work handed from the frame builder to the transmit serializer
   typedef struct packed {
      logic      valid;
      logic      is_frame;
      frame_type frame;
   } job_type;

endpackage

@@ hdl/tpr_frame_build.sv @@
// ----------------------------------------------------------------------------
// Poll responder frame builder
// Tracks the poll flag and frame rotation, and turns one request into a job:
// a poll match, an 8-byte frame with checksum, or nothing.
// ----------------------------------------------------------------------------
module tpr_frame_build (
   input  logic            clock,
   input  logic            reset,
   input  logic            accept,
   input  tpr_pkg::req_type req,
   input  logic [7:0]      device_id,
   output tpr_pkg::job_type job
);
   import tpr_pkg::*;

   logic       poll_armed_ff, poll_armed_in;
   logic [1:0] frame_kind_ff, frame_kind_in;

   logic [15:0] value;
   frame_type   frame;
   logic [10:0] sum_raw;
   logic [8:0]  sum_fold;
   logic [7:0]  sum_final;
   logic        poll_hit;

   always_comb begin
      case (frame_kind_ff)
         KIND_BATT1:  value = req.batt1_mv;
         KIND_BATT2:  value = req.batt2_mv;
         KIND_SWITCH: value = 16'(17'd1 << req.switch_state);
         default:     value = '0;
      endcase
   end

   always_comb begin
      frame = '0;
      if (frame_kind_ff != 2'd3) begin
         frame[0] = HEADER_BYTE;
         frame[1] = {2'b00, frame_kind_ff, 4'b0000};
         frame[2] = TYPE_BYTE;
         frame[3] = value[7:0];
         frame[4] = value[15:8];
      end
      // ones' complement sum: fold carries back in twice
      sum_raw = 11'(frame[0]) + 11'(frame[1]) + 11'(frame[2]) + 11'(frame[3])
              + 11'(frame[4]);
      sum_fold  = 9'(sum_raw[7:0]) + 9'(sum_raw[10:8]);
      sum_final = sum_fold[7:0] + 8'(sum_fold[8]);
      frame[FRAME_BYTES-1] = ~sum_final;
   end

   assign poll_hit = (req.op == OP_RX_BYTE) && (req.rx_byte != START_BYTE)
                     && poll_armed_ff && (req.rx_byte == device_id);

   always_comb begin
      job.valid    = accept && ((req.op == OP_RESP_DUE) || poll_hit);
      job.is_frame = (req.op == OP_RESP_DUE);
      job.frame    = frame;
   end

   always_comb begin
      poll_armed_in = poll_armed_ff;
      frame_kind_in = frame_kind_ff;
      if (accept) begin
         if (req.op == OP_RX_BYTE) begin
            if (req.rx_byte == START_BYTE) begin
               poll_armed_in = 1'b1;
            end else begin
               poll_armed_in = 1'b0;
            end
         end else begin
            frame_kind_in = (frame_kind_ff >= KIND_SWITCH) ? KIND_BATT1
                                                            : frame_kind_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_armed_ff <= 1'b0;
         frame_kind_ff <= KIND_BATT1;
      end else begin
         poll_armed_ff <= poll_armed_in;
         frame_kind_ff <= frame_kind_in;
      end
   end

endmodule

@@ hdl/tpr_tx_serializer.sv @@
// ----------------------------------------------------------------------------
// Poll responder transmit serializer
// Holds one job and hands it out as result transactions, one byte per
// transaction for a frame, a single transaction for a poll match.
// ----------------------------------------------------------------------------
module tpr_tx_serializer (
   input  logic             clock,
   input  logic             reset,
   input  tpr_pkg::job_type job,
   output logic             job_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tpr_pkg::rsp_type rsp_data
);
   import tpr_pkg::*;

   logic                  valid_ff, valid_in;
   logic                  is_frame_ff, is_frame_in;
   frame_type             frame_ff, frame_in;
   logic [BYTE_IDX_W-1:0] idx_ff, idx_in;
   logic                  last_out;
   logic                  fire;

   assign last_out  = !is_frame_ff || (idx_ff == LAST_BYTE_IDX);
   assign fire      = valid_ff && rsp_ready;
   assign job_ready = !valid_ff || (rsp_ready && last_out);

   assign rsp_valid            = valid_ff;
   assign rsp_data.result_kind = is_frame_ff ? RESULT_FRAME_BYTE : RESULT_POLL_MATCH;
   assign rsp_data.tx_byte     = is_frame_ff ? frame_ff[idx_ff] : 8'h00;
   assign rsp_data.tx_last     = is_frame_ff && (idx_ff == LAST_BYTE_IDX);

   always_comb begin
      valid_in    = valid_ff;
      is_frame_in = is_frame_ff;
      frame_in    = frame_ff;
      idx_in      = idx_ff;
      if (fire) begin
         if (last_out) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
      // load the next job as the current one drains
      if (job.valid) begin
         valid_in    = 1'b1;
         is_frame_in = job.is_frame;
         frame_in    = job.frame;
         idx_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      is_frame_ff <= is_frame_in;
      frame_ff    <= frame_in;
   end

endmodule

@@ hdl/telemetry_poll_responder.sv @@
// ----------------------------------------------------------------------------
// Telemetry poll responder
// Sensor side of a polled half-duplex link: matches polls against the device
// ID and serializes rotating battery / switching-state frames.
//
//   Channel   Signals                     Direction  Content
//   req       req_valid/ready/data        in         link byte or response due
//   rsp       rsp_valid/ready/data        out        poll match or frame byte
//   csr       csr_psel..csr_pready        in/out     device_id at offset 0
//
// A request is decoded in the cycle it is accepted; its job lands in the
// serializer register and is shown on rsp the next cycle.
// A frame takes 8 result transactions and a poll match one; a plain link byte
// that is no poll match yields no result.
// req_ready is high while the serializer is empty or its last transaction is being
// taken, so requests overlap the tail of the previous job.
// Synchronous reset clears the poll flag, frame rotation and device_id.
// ----------------------------------------------------------------------------
module telemetry_poll_responder (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  tpr_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output tpr_pkg::rsp_type                  rsp_data,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [tpr_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [31:0]                       csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);
   import tpr_pkg::*;

   logic [7:0] device_id_ff;
   logic       req_accept;
   logic       job_ready;
   job_type    job;
   logic       csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1] == CSR_IDX_DEVICE_ID);
   assign csr_prdata = csr_hit ? {24'h000000, device_id_ff} : 32'h0;

   always_ff @(posedge clock) begin
      if (reset) begin
         device_id_ff <= 8'h00;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         device_id_ff <= csr_pwdata[7:0];
      end
   end

   assign req_ready  = job_ready;
   assign req_accept = req_valid && req_ready;

   tpr_frame_build u_frame_build (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .req       (req_data),
      .device_id (device_id_ff),
      .job       (job)
   );

   tpr_tx_serializer u_tx_serializer (
      .clock     (clock),
      .reset     (reset),
      .job       (job),
      .job_ready (job_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
